// File: src/mds_pkg.sv
`default_nettype none

package mds_pkg;

  // Sizes of the stream fields and configuration registers.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WSZ_W   = 3;
  localparam int unsigned FW_W    = 12;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CIDX_W  = 2;

  // Geometry of the neighbourhood and the line stores.
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned LINES         = 4;
  localparam int unsigned WIN           = 5;
  localparam int unsigned NWIN          = WIN * WIN;
  localparam int unsigned RANK_W        = 5;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  // Register values after reset.
  localparam logic [WSZ_W-1:0] WSZ_RST = 3'd3;
  localparam logic [FW_W-1:0]  FW_RST  = 12'd1920;
  localparam logic [FH_W-1:0]  FH_RST  = 13'd1080;

  typedef enum logic [CIDX_W-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [WSZ_W-1:0] window_size;
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
  } mds_cfg_t;

  // One median job: the window (index row*WIN+col, row and column counted
  // backwards from the newest pixel), the elements taking part and the rank sought.
  typedef struct packed {
    logic [NWIN-1:0][PIX_W-1:0] win;
    logic [NWIN-1:0]            mask;
    logic [RANK_W-1:0]          rank;
    logic                       frame_end;
  } mds_job_t;

  // Index of the lower median in a sorted window of side s.
  function automatic logic [RANK_W-1:0] lower_median_rank(input logic [WSZ_W-1:0] s);
    logic [RANK_W-1:0] r;
    case (s)
      3'd2:    r = 5'd1;
      3'd3:    r = 5'd4;
      3'd4:    r = 5'd7;
      default: r = 5'd12;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/mds_if.sv
`default_nettype none

// Input channel: one pixel word per handshake.
interface mds_pix_if import mds_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

// Output channel: one downscaled pixel word per handshake.
interface mds_out_if import mds_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             frame_end;

  modport source (output valid, output out_pixel, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

// File: src/mds_ram.sv
`default_nettype none

module mds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents when both ports hit one address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: src/mds_front.sv
`default_nettype none

module mds_front import mds_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mds_cfg_t          cfg_i,
  mds_pix_if.sink                in_if,
  input  wire logic [QCNT_W-1:0] q_count_i,
  output logic                   push_o,
  output mds_job_t               job_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);

  logic [WSZ_W-1:0] s_eff;
  logic [WCW-1:0]   w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [1:0]       lo, hi;

  logic             acc;
  logic [XW-1:0]    c0, cur_c, cnt_c_q, cnt_c_d, ox;
  logic [ROW_W-1:0] r0, cur_r, cnt_r_q, cnt_r_d, oy;
  logic [FH_W-1:0]  r1;
  logic             c_wrap, last_c, last_r, ex, ey, infr;
  logic [1:0]       dx, dy;
  logic [WIN-1:0]   rm, cm;
  logic [NWIN-1:0]  mask_d;

  logic             s1_valid_q, s1_emit_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [1:0]       s1_rlo_q;
  logic [NWIN-1:0]  s1_mask_q;
  logic [RANK_W-1:0] s1_rank_q;
  logic             s1_fend_q;

  logic [PIX_W-1:0] rdata [LINES];
  logic [NWIN-1:0][PIX_W-1:0] win_q, win_d;

  // Saturate the configuration into its legal ranges.
  always_comb begin
    if (cfg_i.window_size < 3'd2) s_eff = 3'd2;
    else if (cfg_i.window_size > 3'd5) s_eff = 3'd5;
    else s_eff = cfg_i.window_size;
    if (cfg_i.frame_width < 12'd2) w_eff = WCW'(2);
    else if (int'(cfg_i.frame_width) > int'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
    else w_eff = WCW'(cfg_i.frame_width);
    if (cfg_i.frame_height < 13'd2) h_eff = 13'd2;
    else if (int'(cfg_i.frame_height) > int'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
    else h_eff = cfg_i.frame_height;
  end

  assign lo = 2'((s_eff - 3'd1) >> 1);
  assign hi = 2'(s_eff >> 1);

  // Room in the queue for the word now accepted and the one in flight.
  assign in_if.ready = ({1'b0, q_count_i} + (QCNT_W + 1)'(s1_valid_q && s1_emit_q))
                       < (QCNT_W + 1)'(QDEPTH);
  assign acc = in_if.valid && in_if.ready;

  // Position of the pixel now offered and of the next one.
  always_comb begin
    c0     = in_if.frame_start ? '0 : cnt_c_q;
    r0     = in_if.frame_start ? '0 : cnt_r_q;
    c_wrap = WCW'(c0) >= w_eff;
    cur_c  = c_wrap ? '0 : c0;
    r1     = FH_W'(r0) + FH_W'(c_wrap);
    cur_r  = (r1 >= h_eff) ? '0 : r1[ROW_W-1:0];
    last_c = WCW'(cur_c) == (w_eff - WCW'(1));
    last_r = FH_W'(cur_r) == (h_eff - FH_W'(1));
    if (last_c) begin
      cnt_c_d = '0;
      cnt_r_d = last_r ? '0 : cur_r + ROW_W'(1);
    end else begin
      cnt_c_d = cur_c + XW'(1);
      cnt_r_d = cur_r;
    end
  end

  // Decide whether this pixel completes an output and build its mask.
  always_comb begin
    ex   = last_c || (!cur_c[0] && cur_c >= XW'(2));
    ey   = last_r || (!cur_r[0] && cur_r >= ROW_W'(2));
    dx   = (last_c && cur_c[0]) ? 2'd1 : 2'd2;
    dy   = (last_r && cur_r[0]) ? 2'd1 : 2'd2;
    ox   = cur_c - XW'(dx);
    oy   = cur_r - ROW_W'(dy);
    infr = (ox >= XW'(lo)) && ((WCW'(ox) + WCW'(hi)) < w_eff) &&
           (oy >= ROW_W'(lo)) && ((FH_W'(oy) + FH_W'(hi)) < h_eff);
    for (int d = 0; d < WIN; d++) begin
      rm[d] = ((3'(d) + 3'(hi)) >= 3'(dy)) && (3'(d) <= (3'(dy) + 3'(lo)));
      cm[d] = ((3'(d) + 3'(hi)) >= 3'(dx)) && (3'(d) <= (3'(dx) + 3'(lo)));
    end
    for (int rr = 0; rr < WIN; rr++) begin
      for (int cc = 0; cc < WIN; cc++) begin
        if (infr) mask_d[rr*WIN+cc] = rm[rr] && cm[cc];
        else mask_d[rr*WIN+cc] = (3'(rr) == 3'(dy)) && (3'(cc) == 3'(dx));
      end
    end
  end

  // One line store per row slot, all read at the current column.
  for (genvar k = 0; k < LINES; k++) begin : g_line
    mds_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk_i   (clk_i),
      .we_i    (acc && (cur_r[1:0] == 2'(k))),
      .waddr_i (cur_c),
      .wdata_i (in_if.pixel_value),
      .raddr_i (cur_c),
      .rdata_o (rdata[k])
    );
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_c_q    <= '0;
      cnt_r_q    <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        cnt_c_q   <= cnt_c_d;
        cnt_r_q   <= cnt_r_d;
        s1_emit_q <= ex && ey;
      end
    end
  end

  // Payload of the word waiting for its line-store column.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= in_if.pixel_value;
      s1_rlo_q  <= cur_r[1:0];
      s1_mask_q <= mask_d;
      s1_rank_q <= infr ? lower_median_rank(s_eff) : '0;
      s1_fend_q <= last_c && last_r;
    end
  end

  // Shift the window by one column and bring in the new one.
  always_comb begin
    for (int rr = 0; rr < WIN; rr++) begin
      for (int cc = 0; cc < WIN; cc++) begin
        if (cc != 0) win_d[rr*WIN+cc] = win_q[rr*WIN+cc-1];
        else if (rr == 0) win_d[rr*WIN+cc] = s1_pix_q;
        else win_d[rr*WIN+cc] = rdata[2'(s1_rlo_q - 2'(rr))];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  assign push_o          = s1_valid_q && s1_emit_q;
  assign job_o.win       = win_d;
  assign job_o.mask      = s1_mask_q;
  assign job_o.rank      = s1_rank_q;
  assign job_o.frame_end = s1_fend_q;

endmodule

`default_nettype wire

// File: src/mds_fifo.sv
`default_nettype none

module mds_fifo import mds_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mds_job_t          data_i,
  input  wire logic              pop_i,
  output mds_job_t               data_o,
  output logic                   empty_o,
  output logic [QCNT_W-1:0]      count_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  mds_job_t          mem_q [QDEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign data_o  = mem_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign count_o = cnt_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= step(wr_q);
      if (pop_i) rd_q <= step(rd_q);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/mds_back.sv
`default_nettype none

module mds_back import mds_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mds_job_t job_i,
  input  wire logic     job_valid_i,
  output logic          pop_o,
  mds_out_if.source     out_if
);

  logic en;

  logic                       va_q, vb_q, vo_q;
  logic [NWIN-1:0][NWIN-1:0]  lt_d, lt_q;
  logic [NWIN-1:0][PIX_W-1:0] win_a_q, win_b_q;
  logic [NWIN-1:0]            mask_a_q, hit_d, hit_b_q;
  logic [RANK_W-1:0]          rank_a_q;
  logic                       fend_a_q, fend_b_q, fend_o_q;
  logic [PIX_W-1:0]           val_d, val_o_q;

  // The whole pipe moves whenever the output register can take a word.
  assign en    = !vo_q || out_if.ready;
  assign pop_o = en && job_valid_i;

  // Stable ordering matrix: element i comes before element j.
  always_comb begin
    for (int j = 0; j < NWIN; j++) begin
      for (int i = 0; i < NWIN; i++) begin
        lt_d[j][i] = job_i.mask[i] &&
                     ((job_i.win[i] < job_i.win[j]) ||
                      ((job_i.win[i] == job_i.win[j]) && (i < j)));
      end
    end
  end

  // The element whose count of predecessors equals the rank is the median.
  always_comb begin
    for (int j = 0; j < NWIN; j++) begin
      hit_d[j] = mask_a_q[j] && ($countones(lt_q[j]) == int'(rank_a_q));
    end
  end

  always_comb begin
    val_d = '0;
    for (int j = 0; j < NWIN; j++) begin
      val_d = val_d | (hit_b_q[j] ? win_b_q[j] : '0);
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= job_valid_i;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      lt_q     <= lt_d;
      win_a_q  <= job_i.win;
      mask_a_q <= job_i.mask;
      rank_a_q <= job_i.rank;
      fend_a_q <= job_i.frame_end;
      hit_b_q  <= hit_d;
      win_b_q  <= win_a_q;
      fend_b_q <= fend_a_q;
      val_o_q  <= val_d;
      fend_o_q <= fend_b_q;
    end
  end

  assign out_if.valid     = vo_q;
  assign out_if.out_pixel = val_o_q;
  assign out_if.frame_end = fend_o_q;

endmodule

`default_nettype wire

// File: src/median_downscale_2x.sv
// Median 2x downscaler for one 8-bit image plane.
// Input channel in_if carries one pixel word per handshake in raster order;
// frame_start marks the first pixel of a plane. Output channel out_if
// carries a word for each even column and row bar the last ones: the lower
// median of a window_size x window_size neighbourhood, or the centre pixel
// where that window leaves the frame; frame_end marks the last word.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, index 0
// window size, 1 frame width, 2 frame height; the user must write them
// only while idle; the block does not enforce it. While ready is high,
// throughput is one pixel per cycle. A result passes the line-store read
// register, the job queue and the rank ordering, hit and output registers.
// Reset clears the position counters, queue and pipeline valid flags and
// restores the registers to 3, 1920 and 1080; line stores are not cleared.
// When the receiver stalls, the rank pipeline holds and the four-entry job
// queue fills; the input channel then drops ready until room returns.
`default_nettype none

module median_downscale_2x import mds_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mds_pix_if.sink                in_if,
  mds_out_if.source              out_if,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  mds_cfg_t          cfg_q;
  mds_job_t          push_job, head_job;
  logic              push, pop, empty;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size  <= WSZ_RST;
      cfg_q.frame_width  <= FW_RST;
      cfg_q.frame_height <= FH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_SIZE:  cfg_q.window_size  <= cfg_data_i[WSZ_W-1:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking, line stores and window.
  mds_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_if     (in_if),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (push_job)
  );

  // Job queue between the two halves.
  mds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty),
    .count_o (q_count)
  );

  // Rank selection and output register.
  mds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!empty),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
